>>> sv/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 4;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;
	localparam logic [5:0] PLUS_VAL   = 6'd62;
	localparam logic [5:0] SLASH_VAL  = 6'd63;
	localparam logic [5:0] LOWER_OFS  = 6'd26;
	localparam logic [5:0] DIGIT_OFS  = 6'd52;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;
	localparam logic [1:0] PH_FOURTH = 2'd3;

	typedef struct packed {
		logic [5:0] sextet;
		logic       is_bad;
		logic       is_pad;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_flag;
		logic       bad_input;
	} result_t;

	// bit 6 marks a character outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'd0;
		r = {1'b1, 6'd0};
		if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h41;
			r = {1'b0, d[5:0]};
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'h61;
			r = {1'b0, d[5:0] + LOWER_OFS};
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
			r = {1'b0, d[5:0] + DIGIT_OFS};
		end else if (c == PLUS_CHAR) begin
			r = {1'b0, PLUS_VAL};
		end else if (c == SLASH_CHAR) begin
			r = {1'b0, SLASH_VAL};
		end
		return r;
	endfunction

endpackage

>>> sv/b64d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_fifo
// Small register queue with full and empty flags; a push and a pop can both take effect in the same cycle.
// ----------------------------------------------------------------------------
module b64d_fifo import b64d_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = MID_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters and classifies them into sextet, padding and bad marks.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
	input  logic       push,
	input  logic       q_full,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       q_wr,
	output item_t      q_item
);

	logic [6:0] lookup;

	assign lookup         = sextet_of(char_code);
	assign q_wr           = push && !q_full;
	assign q_item.sextet  = lookup[5:0];
	assign q_item.is_bad  = lookup[6];
	assign q_item.is_pad  = (char_code == PAD_CHAR);
	assign q_item.last    = end_of_text;

endmodule

>>> sv/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Group phase tracking, byte assembly, padding and error handling.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_avail,
	input  item_t   item,
	output logic    item_take,
	input  logic    res_full,
	output logic    res_wr,
	output result_t res
);

	logic [1:0] phase_q;
	logic [5:0] held_q;
	logic       closed_q;
	logic       discard_q;

	logic [1:0] phase_d;
	logic [5:0] held_d;
	logic       closed_d;
	logic       discard_d;
	logic       emit;
	result_t    r;

	assign item_take = item_avail && !res_full;
	assign res_wr    = item_take && emit;
	assign res       = r;

	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		closed_d  = closed_q;
		discard_d = discard_q;
		emit      = 1'b0;
		r         = '0;
		if (discard_q) begin
			if (item.last) begin
				emit       = 1'b1;
				r.end_flag  = 1'b1;
				r.bad_input = 1'b1;
			end
		end else if (closed_q) begin
			closed_d = 1'b0;
			phase_d  = PH_FIRST;
			if (item.last) begin
				emit      = 1'b1;
				r.end_flag = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_FIRST: begin
					if (item.is_bad || item.last) begin
						emit        = 1'b1;
						r.bad_input = 1'b1;
						r.end_flag  = item.last;
						discard_d   = !item.last;
					end else begin
						held_d  = item.sextet;
						phase_d = PH_SECOND;
					end
				end
				PH_SECOND: begin
					emit = 1'b1;
					if (item.is_bad) begin
						r.bad_input = 1'b1;
						r.end_flag  = item.last;
						discard_d   = !item.last;
					end else begin
						r.out_byte   = {held_q, item.sextet[5:4]};
						r.byte_valid = 1'b1;
						r.end_flag   = item.last;
						held_d       = item.sextet;
						phase_d      = PH_THIRD;
					end
				end
				PH_THIRD: begin
					if (item.is_pad) begin
						if (item.last) begin
							emit       = 1'b1;
							r.end_flag = 1'b1;
						end else begin
							closed_d = 1'b1;
						end
					end else if (item.is_bad) begin
						emit        = 1'b1;
						r.bad_input = 1'b1;
						r.end_flag  = item.last;
						discard_d   = !item.last;
					end else begin
						emit         = 1'b1;
						r.out_byte   = {held_q[3:0], item.sextet[5:2]};
						r.byte_valid = 1'b1;
						r.end_flag   = item.last;
						held_d       = item.sextet;
						phase_d      = PH_FOURTH;
					end
				end
				PH_FOURTH: begin
					if (item.is_pad) begin
						phase_d = PH_FIRST;
						held_d  = '0;
						if (item.last) begin
							emit       = 1'b1;
							r.end_flag = 1'b1;
						end
					end else if (item.is_bad) begin
						emit        = 1'b1;
						r.bad_input = 1'b1;
						r.end_flag  = item.last;
						discard_d   = !item.last;
					end else begin
						emit         = 1'b1;
						r.out_byte   = {held_q[1:0], item.sextet};
						r.byte_valid = 1'b1;
						r.end_flag   = item.last;
						phase_d      = PH_FIRST;
						held_d       = '0;
					end
				end
				default: begin
					phase_d = PH_FIRST;
				end
			endcase
		end
		// end of message clears everything
		if (item.last) begin
			phase_d   = PH_FIRST;
			held_d    = '0;
			closed_d  = 1'b0;
			discard_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			held_q    <= '0;
			closed_q  <= 1'b0;
			discard_q <= 1'b0;
		end else if (item_take) begin
			phase_q   <= phase_d;
			held_q    <= held_d;
			closed_q  <= closed_d;
			discard_q <= discard_d;
		end
	end

endmodule

>>> sv/base64_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming Base64 decoder, standard alphabet, one character per transaction.
// ----------------------------------------------------------------------------
//  channel  | handshake        | fields
//  input    | push / full      | char_code, end_of_text
//  result   | pop / empty      | out_byte, byte_valid, end_flag, bad_input
//
//  one character per cycle sustained while the result queue has room; a
//  character waits in the character queue, its result in the result queue;
//  the decode step handles one character a cycle and emits at most one result
//  a full result queue stalls decode, a full character queue raises full
//  reset clears both queues and the group state; no clearing pass
// ----------------------------------------------------------------------------
module base64_decoder import b64d_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_flag,
	output logic       bad_input
);

	logic    mid_wr;
	item_t   mid_wr_item;
	logic    mid_full;
	logic    mid_rd;
	item_t   mid_rd_item;
	logic    mid_empty;
	logic    res_wr;
	result_t res_wr_data;
	logic    res_full;
	result_t res_rd_data;

	assign full = mid_full;

	b64d_front u_front (
		.push        (push),
		.q_full      (mid_full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.q_wr        (mid_wr),
		.q_item      (mid_wr_item)
	);

	b64d_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wr_item),
		.full    (mid_full),
		.rd_en   (mid_rd),
		.rd_data (mid_rd_item),
		.empty   (mid_empty)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_avail (!mid_empty),
		.item       (mid_rd_item),
		.item_take  (mid_rd),
		.res_full   (res_full),
		.res_wr     (res_wr),
		.res        (res_wr_data)
	);

	b64d_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_wr_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd_data),
		.empty   (empty)
	);

	assign out_byte   = res_rd_data.out_byte;
	assign byte_valid = res_rd_data.byte_valid;
	assign end_flag   = res_rd_data.end_flag;
	assign bad_input  = res_rd_data.bad_input;

endmodule
